FILE: rtl/ncrt_pkg.sv
// ============================================================================
// ncrt_pkg: shared types and constants for the node coverage relay table
// Holds command and node type codes, register indexes, beat payload types.
// ============================================================================
package ncrt_pkg;

    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_DEREGISTER = 2'd1;

    localparam logic [1:0] TYPE_TERMINAL = 2'd0;
    localparam logic [1:0] TYPE_BASE     = 2'd1;

    localparam logic [1:0] REG_HUB_ID    = 2'd0;
    localparam logic [1:0] REG_BCAST_ID  = 2'd1;
    localparam logic [1:0] REG_RADIUS    = 2'd2;

    localparam int MAX_RESULTS = 32;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        src_id;
        logic [31:0]        dst_id;
        logic [1:0]         node_type;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        sender_address;
        logic [15:0]        src_port;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic        reply_ok;
        logic [31:0] dest_node_id;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_item_t;

    // Classified job handed from front to back
    typedef enum logic [2:0] {
        JOB_REGISTER,
        JOB_DEREGISTER,
        JOB_IGNORE,
        JOB_BROADCAST,
        JOB_UNICAST
    } job_kind_t;

    typedef struct packed {
        job_kind_t kind;
        in_item_t  item;
    } job_t;

endpackage

FILE: rtl/ncrt_if.sv
// ============================================================================
// ncrt_if: valid/ready channels
// Input item, result item and configuration write channels.
// ============================================================================
interface ncrt_in_if;
    logic              valid;
    logic              ready;
    ncrt_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ncrt_out_if;
    logic               valid;
    logic               ready;
    ncrt_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ncrt_cfg_if;
    logic               valid;
    logic               ready;
    ncrt_pkg::cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ncrt_front.sv
// ============================================================================
// ncrt_front: accept and classify beats
// Tags each input beat with its job kind and pushes it into a short queue.
// ============================================================================
module ncrt_front #(
    parameter int QDEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    ncrt_in_if.sink             in_ch,
    input  logic [31:0]         hub_id,
    input  logic [31:0]         bcast_id,
    input  logic                pop,
    output logic                job_valid,
    output ncrt_pkg::job_t      job
);
    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    ncrt_pkg::job_t   q_mem [QDEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    ncrt_pkg::job_kind_t kind_next;
    logic             push;

    // Classify: hub messages first, then broadcast, then unicast
    always_comb
    begin
        if (in_ch.data.dst_id == hub_id)
        begin
            if (in_ch.data.command == ncrt_pkg::CMD_REGISTER)
                kind_next = ncrt_pkg::JOB_REGISTER;
            else if (in_ch.data.command == ncrt_pkg::CMD_DEREGISTER)
                kind_next = ncrt_pkg::JOB_DEREGISTER;
            else
                kind_next = ncrt_pkg::JOB_IGNORE;
        end
        else if (in_ch.data.dst_id == bcast_id)
            kind_next = ncrt_pkg::JOB_BROADCAST;
        else
            kind_next = ncrt_pkg::JOB_UNICAST;
    end

    assign in_ch.ready = (count_reg != (AW+1)'(QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign job_valid   = (count_reg != '0);
    assign job         = q_mem[rd_ptr_reg];

    // Write queue entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg].kind <= kind_next;
            q_mem[wr_ptr_reg].item <= in_ch.data;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> job_valid) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(QDEPTH)) else $error("queue overflow");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == (AW+1)'(QDEPTH)) |-> !in_ch.ready) else $error("full not stalled");

endmodule

FILE: rtl/ncrt_back.sv
// ============================================================================
// ncrt_back: table walker
// Scans the node table one slot per cycle to search, then registers, refreshes
// and delivers. Holds the table in per-slot registers and drives result beats.
// ============================================================================
module ncrt_back #(
    parameter int NODE_SLOTS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  ncrt_pkg::job_t      job,
    output logic                pop,
    input  logic [31:0]         hub_id,
    input  logic [31:0]         bcast_id,
    input  logic [15:0]         coverage_radius,
    ncrt_out_if.source          out_ch
);
    localparam int SW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int CW = $clog2(NODE_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DIST, S_MUL, S_CMP, S_ACT, S_WALK, S_WMUL, S_WCMP,
        S_EMIT, S_DONE
    } state_t;

    // Table storage
    logic                slot_valid_reg [NODE_SLOTS];
    logic [31:0]         slot_id_mem    [NODE_SLOTS];
    logic                slot_base_mem  [NODE_SLOTS];
    logic signed [15:0]  slot_x_mem     [NODE_SLOTS];
    logic signed [15:0]  slot_y_mem     [NODE_SLOTS];
    logic [31:0]         slot_addr_mem  [NODE_SLOTS];
    logic [15:0]         slot_port_mem  [NODE_SLOTS];

    state_t              state_reg;
    logic [CW-1:0]       idx_reg;
    logic                src_hit_reg, dst_hit_reg, typ_hit_reg, any_hit_reg, free_hit_reg;
    logic [SW-1:0]       src_reg, dst_reg, typ_reg, free_reg;
    logic                src_base_reg;
    logic                bcast_reg;
    logic [SW-1:0]       peer_reg;
    logic signed [15:0]  sx_reg, sy_reg;
    logic [16:0]         ax_reg, ay_reg;
    logic [33:0]         sq_reg;
    logic [31:0]         r2_reg;
    logic [5:0]          sent_reg;
    logic                out_valid_reg;
    ncrt_pkg::out_item_t out_reg;
    ncrt_pkg::out_item_t pend_reg;

    ncrt_pkg::in_item_t  it;
    logic [SW-1:0]       idx;
    logic                id_match;
    logic signed [16:0]  dx, dy;
    logic [33:0]         sq_sum;
    logic                deliver_ok;
    logic                wait_out;
    logic                out_free;

    assign it       = job.item;
    assign idx      = idx_reg[SW-1:0];
    assign id_match = slot_valid_reg[idx] && (slot_id_mem[idx] == it.src_id);
    assign dx       = 17'(sx_reg) - 17'(slot_x_mem[peer_reg]);
    assign dy       = 17'(sy_reg) - 17'(slot_y_mem[peer_reg]);
    assign sq_sum   = 34'(ax_reg * ax_reg) + 34'(ay_reg * ay_reg);
    assign wait_out = out_valid_reg && !out_ch.ready;
    assign out_free = !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;
    assign pop      = (state_reg == S_DONE);
    assign deliver_ok = (sq_reg <= 34'(r2_reg));

    // Sequencer: scan, then act, then walk for broadcast
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            sent_reg      <= '0;
            for (int i = 0; i < NODE_SLOTS; i++)
                slot_valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        idx_reg <= '0;
                        src_hit_reg <= 1'b0; dst_hit_reg <= 1'b0;
                        typ_hit_reg <= 1'b0; any_hit_reg <= 1'b0;
                        free_hit_reg <= 1'b0;
                        sent_reg <= '0;
                        r2_reg <= 32'(coverage_radius * coverage_radius);
                        state_reg <= (job.kind == ncrt_pkg::JOB_IGNORE) ? S_DONE : S_SCAN;
                    end
                end
                // Search: lowest matching slot of each kind
                S_SCAN:
                begin
                    if (id_match && !src_hit_reg)
                    begin
                        src_hit_reg <= 1'b1; src_reg <= idx;
                        src_base_reg <= slot_base_mem[idx];
                    end
                    if (slot_valid_reg[idx] && slot_id_mem[idx] == it.dst_id && !dst_hit_reg)
                    begin
                        dst_hit_reg <= 1'b1; dst_reg <= idx;
                    end
                    if (id_match && !typ_hit_reg && it.node_type[1] == 1'b0
                        && slot_base_mem[idx] == it.node_type[0])
                    begin
                        typ_hit_reg <= 1'b1; typ_reg <= idx;
                    end
                    if (id_match)
                        any_hit_reg <= 1'b1;
                    if (!slot_valid_reg[idx] && !free_hit_reg)
                    begin
                        free_hit_reg <= 1'b1; free_reg <= idx;
                    end
                    if (idx_reg == CW'(NODE_SLOTS - 1))
                        state_reg <= S_ACT;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_ACT:
                begin
                    priority case (job.kind)
                        ncrt_pkg::JOB_REGISTER:
                        begin
                            if (out_free)
                            begin
                                out_valid_reg <= 1'b1;
                                out_reg.kind <= 1'b0;
                                out_reg.dest_node_id <= it.src_id;
                                out_reg.dest_address <= it.sender_address;
                                out_reg.dest_port <= it.src_port;
                                out_reg.last <= 1'b1;
                                if (it.src_id != hub_id && it.src_id != bcast_id
                                    && !any_hit_reg && !it.node_type[1] && free_hit_reg)
                                begin
                                    out_reg.reply_ok <= 1'b1;
                                    slot_valid_reg[free_reg] <= 1'b1;
                                    slot_id_mem[free_reg]   <= it.src_id;
                                    slot_base_mem[free_reg] <= it.node_type[0];
                                    slot_x_mem[free_reg]    <= it.pos_x;
                                    slot_y_mem[free_reg]    <= it.pos_y;
                                    slot_addr_mem[free_reg] <= it.sender_address;
                                    slot_port_mem[free_reg] <= it.src_port;
                                end
                                else
                                    out_reg.reply_ok <= 1'b0;
                                state_reg <= S_DONE;
                            end
                        end
                        ncrt_pkg::JOB_DEREGISTER:
                        begin
                            if (typ_hit_reg)
                                slot_valid_reg[typ_reg] <= 1'b0;
                            state_reg <= S_DONE;
                        end
                        ncrt_pkg::JOB_BROADCAST:
                        begin
                            if (typ_hit_reg)
                            begin
                                slot_x_mem[typ_reg] <= it.pos_x;
                                slot_y_mem[typ_reg] <= it.pos_y;
                            end
                            sx_reg <= (typ_hit_reg && typ_reg == src_reg) ? it.pos_x
                                      : slot_x_mem[src_reg];
                            sy_reg <= (typ_hit_reg && typ_reg == src_reg) ? it.pos_y
                                      : slot_y_mem[src_reg];
                            idx_reg <= '0;
                            bcast_reg <= 1'b1;
                            state_reg <= (src_hit_reg && src_base_reg) ? S_WALK : S_DONE;
                        end
                        default:
                        begin
                            if (typ_hit_reg)
                            begin
                                slot_x_mem[typ_reg] <= it.pos_x;
                                slot_y_mem[typ_reg] <= it.pos_y;
                            end
                            sx_reg <= (typ_hit_reg && typ_reg == src_reg) ? it.pos_x
                                      : slot_x_mem[src_reg];
                            sy_reg <= (typ_hit_reg && typ_reg == src_reg) ? it.pos_y
                                      : slot_y_mem[src_reg];
                            bcast_reg <= 1'b0;
                            peer_reg <= dst_reg;
                            state_reg <= (src_hit_reg && dst_hit_reg &&
                                (src_base_reg || slot_base_mem[dst_reg])) ? S_DIST : S_DONE;
                        end
                    endcase
                end
                // Walk: one slot per visit for broadcast
                S_WALK:
                begin
                    if (idx_reg == CW'(NODE_SLOTS) || sent_reg == 6'(ncrt_pkg::MAX_RESULTS))
                        state_reg <= S_EMIT;
                    else if (slot_valid_reg[idx] && !slot_base_mem[idx])
                    begin
                        peer_reg <= idx;
                        state_reg <= S_DIST;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_DIST:
                begin
                    ax_reg <= dx[16] ? 17'(-dx) : 17'(dx);
                    ay_reg <= dy[16] ? 17'(-dy) : 17'(dy);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    sq_reg <= sq_sum;
                    state_reg <= S_CMP;
                end
                // Deliver: load the output register only when it is empty
                S_CMP:
                begin
                    if (out_free)
                    begin
                        if (deliver_ok && !bcast_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_reg <= '{1'b1, 1'b0, slot_id_mem[peer_reg],
                                        slot_addr_mem[peer_reg], slot_port_mem[peer_reg], 1'b1};
                            state_reg <= S_DONE;
                        end
                        else if (!bcast_reg)
                            state_reg <= S_DONE;
                        else
                        begin
                            if (deliver_ok)
                            begin
                                // Send previous pending, stage this one
                                if (sent_reg != '0)
                                begin
                                    out_valid_reg <= 1'b1;
                                    out_reg <= pend_reg;
                                end
                                pend_reg <= '{1'b1, 1'b0, slot_id_mem[peer_reg],
                                             slot_addr_mem[peer_reg], slot_port_mem[peer_reg],
                                             1'b0};
                                sent_reg <= sent_reg + 1'b1;
                            end
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_WALK;
                        end
                    end
                end
                // Close: send the staged delivery flagged as last
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        if (sent_reg != '0)
                        begin
                            out_valid_reg <= 1'b1;
                            out_reg <= '{pend_reg.kind, pend_reg.reply_ok, pend_reg.dest_node_id,
                                        pend_reg.dest_address, pend_reg.dest_port, 1'b1};
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_pop_once: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !pop) else $error("double pop");
    a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg <= 6'(ncrt_pkg::MAX_RESULTS)) else $error("too many deliveries");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wait_out |=> out_valid_reg && $stable(out_reg)) else $error("result dropped");

endmodule

FILE: rtl/node_coverage_relay_table.sv
// ============================================================================
// node_coverage_relay_table: hub node table with coverage relay
// Registers, removes and relays between terminals and base stations.
// ============================================================================
// One packet header is taken per beat into a two-entry queue; for each header
// that is not ignored the walker then scans every table slot once and acts.
// A unicast adds distance, square and compare steps, and a broadcast adds a
// second walk over the table with those three steps per terminal visited.
// The walker takes one header at a time from the head of the queue and pops it
// when done. Result beats are held in an output register until taken, and the
// next result waits until it is empty; the queue keeps accepting while the
// walker stalls, until the queue is full.
module node_coverage_relay_table #(
    parameter int NODE_SLOTS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ncrt_in_if.sink   in_ch,
    ncrt_cfg_if.sink  cfg,
    ncrt_out_if.source out_ch
);
    logic [31:0]     hub_id_reg, bcast_id_reg;
    logic [15:0]     radius_reg;
    logic            job_valid, pop;
    ncrt_pkg::job_t  job;

    assign cfg.ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hub_id_reg   <= 32'd0;
            bcast_id_reg <= 32'hFFFF_FFFF;
            radius_reg   <= 16'd1000;
        end
        else if (cfg.valid)
        begin
            if (cfg.data.index == ncrt_pkg::REG_HUB_ID)
                hub_id_reg <= cfg.data.data;
            else if (cfg.data.index == ncrt_pkg::REG_BCAST_ID)
                bcast_id_reg <= cfg.data.data;
            else if (cfg.data.index == ncrt_pkg::REG_RADIUS)
                radius_reg <= cfg.data.data[15:0];
        end
    end

    ncrt_front #(.QDEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .hub_id(hub_id_reg), .bcast_id(bcast_id_reg),
        .pop(pop), .job_valid(job_valid), .job(job)
    );

    ncrt_back #(.NODE_SLOTS(NODE_SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job), .pop(pop),
        .hub_id(hub_id_reg), .bcast_id(bcast_id_reg),
        .coverage_radius(radius_reg), .out_ch(out_ch)
    );

endmodule
